@@ hdl/alpd_pkg.sv @@
// Package for the armed long-press detector: timer and register widths,
// register indexes, reset values, state and result types, timer helpers.
// No dependencies.
`default_nettype none

package alpd_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CMP_W       = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  typedef logic [TIMER_WIDTH-1:0] timer_t;
  typedef logic [CFG_W-1:0]       cfg_word_t;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_DEBOUNCE   = 3'd1,
    REG_ARM        = 3'd2,
    REG_HOLD       = 3'd3,
    REG_EXEC_DELAY = 3'd4
  } cfg_reg_t;

  localparam logic      ENABLE_RESET   = 1'b1;
  localparam cfg_word_t DEBOUNCE_RESET = 16'd40;
  localparam cfg_word_t ARM_RESET      = 16'd500;
  localparam cfg_word_t HOLD_RESET     = 16'd10000;
  localparam cfg_word_t EXEC_RESET     = 16'd900;

  typedef struct packed {
    logic      enable;
    cfg_word_t debounce_ticks;
    cfg_word_t arm_ticks;
    cfg_word_t hold_ticks;
    cfg_word_t exec_delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic   raw_level;
    timer_t since_change;
    logic   stable_level;
    logic   armed_flag;
    logic   release_seen;
    timer_t release_timer;
    logic   press_seen;
    timer_t press_timer;
    logic   fired;
    logic   pending_flag;
    timer_t exec_timer;
    logic   exec_done;
  } state_t;

  typedef struct packed {
    logic stable_pressed;
    logic armed;
    logic holding;
    logic trigger_pulse;
    logic pending;
    logic execute_pulse;
  } result_t;

  function automatic timer_t sat_inc(input timer_t v);
    return (v == '1) ? v : v + timer_t'(1);
  endfunction

  // timer >= limit, both zero-extended to a common width
  function automatic logic reached(input timer_t t, input cfg_word_t lim);
    logic [CMP_W-1:0] a;
    logic [CMP_W-1:0] b;
    a = CMP_W'(t);
    b = CMP_W'(lim);
    return a >= b;
  endfunction

endpackage

`default_nettype wire

@@ hdl/alpd_tick_if.sv @@
// Input channel: one tick word with the raw button level and failure flag.
// No dependencies.
`default_nettype none

interface alpd_tick_if;
  logic valid;
  logic ready;
  logic raw_pressed;
  logic command_failed;

  modport source (output valid, raw_pressed, command_failed, input ready);
  modport sink   (input valid, raw_pressed, command_failed, output ready);
endinterface

`default_nettype wire

@@ hdl/alpd_status_if.sv @@
// Output channel: one status word per tick.
// No dependencies.
`default_nettype none

interface alpd_status_if;
  logic valid;
  logic ready;
  logic stable_pressed;
  logic armed;
  logic holding;
  logic trigger_pulse;
  logic pending;
  logic execute_pulse;

  modport source (output valid, stable_pressed, armed, holding, trigger_pulse,
                  pending, execute_pulse, input ready);
  modport sink   (input valid, stable_pressed, armed, holding, trigger_pulse,
                  pending, execute_pulse, output ready);
endinterface

`default_nettype wire

@@ hdl/alpd_core.sv @@
// Detector state and its one-tick update: debounce, arming, hold timer,
// pending flag and execute delay. Depends on alpd_pkg.
`default_nettype none

module alpd_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic             raw_pressed,
  input  wire logic             command_failed,
  input  wire alpd_pkg::cfg_t   cfg,
  output alpd_pkg::result_t     result
);

  alpd_pkg::state_t st;
  alpd_pkg::state_t st_next;
  logic             trig;
  logic             exec;

  always_comb begin
    st_next = st;
    trig    = 1'b0;
    exec    = 1'b0;
    if (cfg.enable) begin
      if (!st.pending_flag) begin
        // debounce
        if (raw_pressed != st.raw_level) begin
          st_next.raw_level    = raw_pressed;
          st_next.since_change = '0;
        end else begin
          st_next.since_change = alpd_pkg::sat_inc(st.since_change);
        end
        if (alpd_pkg::reached(st_next.since_change, cfg.debounce_ticks)) begin
          st_next.stable_level = st_next.raw_level;
        end

        if (!st.armed_flag) begin
          if (st_next.stable_level) begin
            st_next.release_seen = 1'b0;
            st_next.press_seen   = 1'b0;
            st_next.fired        = 1'b0;
          end else if (!st.release_seen) begin
            st_next.release_seen  = 1'b1;
            st_next.release_timer = '0;
          end else begin
            st_next.release_timer = alpd_pkg::sat_inc(st.release_timer);
            if (alpd_pkg::reached(st_next.release_timer, cfg.arm_ticks)) begin
              st_next.armed_flag = 1'b1;
            end
          end
        end else begin
          if (!st_next.stable_level) begin
            st_next.press_seen = 1'b0;
            st_next.fired      = 1'b0;
          end else if (!st.press_seen) begin
            st_next.press_seen  = 1'b1;
            st_next.press_timer = '0;
          end else if (!st.fired) begin
            st_next.press_timer = alpd_pkg::sat_inc(st.press_timer);
            if (alpd_pkg::reached(st_next.press_timer, cfg.hold_ticks)) begin
              st_next.fired = 1'b1;
              trig          = 1'b1;
            end
          end
        end

        if (trig) begin
          st_next.pending_flag = 1'b1;
          st_next.exec_timer   = '0;
          st_next.exec_done    = 1'b0;
        end
      end

      // execute delay; the trigger tick itself does not count
      if (st_next.pending_flag && !st_next.exec_done) begin
        if (!trig) begin
          st_next.exec_timer = alpd_pkg::sat_inc(st_next.exec_timer);
        end
        if (alpd_pkg::reached(st_next.exec_timer, cfg.exec_delay_ticks)) begin
          st_next.exec_done = 1'b1;
          exec              = 1'b1;
        end
      end

      if (st_next.pending_flag && st_next.exec_done && command_failed) begin
        st_next.pending_flag = 1'b0;
      end
    end
  end

  always_comb begin
    result.stable_pressed = st_next.stable_level;
    result.armed          = st_next.armed_flag;
    result.holding        = st_next.press_seen && !st_next.fired;
    result.trigger_pulse  = trig;
    result.pending        = st_next.pending_flag;
    result.execute_pulse  = exec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/armed_long_press_detector_unit.sv @@
// Top level of the armed long-press detector: configuration registers,
// input register, result register. Depends on alpd_pkg, alpd_tick_if,
// alpd_status_if and alpd_core.
//
//   channel   direction  word
//   ticks     in         raw_pressed, command_failed (one per ms tick)
//   status    out        stable_pressed, armed, holding, trigger_pulse,
//                        pending, execute_pulse
//   cfg_*     in         write enable, 3-bit register index, 16-bit data
//
// One word per cycle sustained while status is ready. A tick goes into the
// input register, then its state update into the result register; a stall
// on status can hold it in the input register between the two. The state
// update is a few 16-bit increments and compares. rst is synchronous:
// state clears, registers take reset values. A stalled status word holds;
// the input register keeps filling as long as the result register drains.
`default_nettype none

module armed_long_press_detector_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  alpd_tick_if.sink                              ticks,
  alpd_status_if.source                          status,
  input  wire logic                              cfg_we,
  input  wire logic [alpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [alpd_pkg::CFG_W-1:0]        cfg_data
);

  alpd_pkg::cfg_t    cfg;
  logic              in_valid;
  logic              in_raw;
  logic              in_failed;
  logic              out_valid;
  alpd_pkg::result_t out_word;
  alpd_pkg::result_t result;
  logic              advance;
  logic              step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable           <= alpd_pkg::ENABLE_RESET;
      cfg.debounce_ticks   <= alpd_pkg::DEBOUNCE_RESET;
      cfg.arm_ticks        <= alpd_pkg::ARM_RESET;
      cfg.hold_ticks       <= alpd_pkg::HOLD_RESET;
      cfg.exec_delay_ticks <= alpd_pkg::EXEC_RESET;
    end else if (cfg_we) begin
      unique case (alpd_pkg::cfg_reg_t'(cfg_index))
        alpd_pkg::REG_ENABLE:     cfg.enable           <= cfg_data[0];
        alpd_pkg::REG_DEBOUNCE:   cfg.debounce_ticks   <= cfg_data;
        alpd_pkg::REG_ARM:        cfg.arm_ticks        <= cfg_data;
        alpd_pkg::REG_HOLD:       cfg.hold_ticks       <= cfg_data;
        alpd_pkg::REG_EXEC_DELAY: cfg.exec_delay_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance     = !out_valid || status.ready;
  assign step        = in_valid && advance;
  assign ticks.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (ticks.ready) begin
      in_valid <= ticks.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ticks.ready && ticks.valid) begin
      in_raw    <= ticks.raw_pressed;
      in_failed <= ticks.command_failed;
    end
  end

  alpd_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .raw_pressed    (in_raw),
    .command_failed (in_failed),
    .cfg            (cfg),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word <= result;
    end
  end

  assign status.valid          = out_valid;
  assign status.stable_pressed = out_word.stable_pressed;
  assign status.armed          = out_word.armed;
  assign status.holding        = out_word.holding;
  assign status.trigger_pulse  = out_word.trigger_pulse;
  assign status.pending        = out_word.pending;
  assign status.execute_pulse  = out_word.execute_pulse;

endmodule

`default_nettype wire
